>>> rtl/plvs_pkg.sv
// shared widths, register map and word types for the prefetch-aware lru victim select
`default_nettype none

package plvs_pkg;

    localparam int TICK_W       = 62;
    localparam int RANK_W       = 64;
    localparam int IDX_W        = 3;
    localparam int WAYS_DEFAULT = 8;

    // configuration port: one 62-bit register at byte address 0, 8-byte stride
    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 4;
    localparam int REG_SEL_LSB  = 3;

    localparam logic REG_PREFETCH_GAP = 1'b0;

    // smallest 64-bit signed rank, used when the adjusted rank underflows
    localparam logic signed [RANK_W-1:0] RANK_MIN = {1'b1, {(RANK_W-1){1'b0}}};

    typedef struct packed {
        logic signed [RANK_W-1:0] rank;
        logic [TICK_W-1:0]        tick;
        logic                     last;
    } rank_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [TICK_W-1:0] tick;
    } victim_t;

endpackage

`default_nettype wire

>>> rtl/plvs_rank.sv
// rank of one candidate: raw touch time or prefetch-adjusted value
`default_nettype none

module plvs_rank (
    input  wire logic [plvs_pkg::TICK_W-1:0]        now_tick,
    input  wire logic [plvs_pkg::TICK_W-1:0]        candidate_tick,
    input  wire logic                               was_prefetched,
    input  wire logic [plvs_pkg::TICK_W-1:0]        prefetch_gap,
    output logic signed [plvs_pkg::RANK_W-1:0]      rank
);
    import plvs_pkg::*;

    localparam int SUM_W = TICK_W + 1;
    localparam int ADJ_W = RANK_W + 1;

    logic [SUM_W-1:0]        touch_plus_gap;
    logic                    in_window;
    logic signed [ADJ_W-1:0] adj_rank;
    logic                    underflow;

    // 63-bit sum cannot wrap, so the window test is exact
    assign touch_plus_gap = {1'b0, candidate_tick} + {1'b0, prefetch_gap};
    assign in_window      = touch_plus_gap > {1'b0, now_tick};

    // 2*(now - gap) - tick in 65 bits, always representable
    assign adj_rank = $signed({2'b00, now_tick, 1'b0})
                    - $signed({2'b00, prefetch_gap, 1'b0})
                    - $signed({3'b000, candidate_tick});

    // below -2^63 when sign set but bit 63 clear
    assign underflow = adj_rank[ADJ_W-1] & ~adj_rank[ADJ_W-2];

    always_comb begin
        if (was_prefetched && in_window) begin
            rank = underflow ? RANK_MIN : adj_rank[RANK_W-1:0];
        end else begin
            rank = $signed({2'b00, candidate_tick});
        end
    end

endmodule

`default_nettype wire

>>> rtl/plvs_select.sv
// running minimum over the candidates of one set, winner state and position count
`default_nettype none

module plvs_select #(
    parameter int WAYS = plvs_pkg::WAYS_DEFAULT
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    fire,
    input  wire plvs_pkg::rank_word_t    item,
    output plvs_pkg::victim_t            winner
);
    import plvs_pkg::*;

    localparam int PW    = $clog2(WAYS);
    localparam int EXT_W = PW + IDX_W;
    localparam logic [PW-1:0] POS_MAX = PW'(WAYS - 1);

    logic signed [RANK_W-1:0] best_rank_reg, best_rank_next;
    logic [TICK_W-1:0]        best_tick_reg, best_tick_next;
    logic [PW-1:0]            best_pos_reg,  best_pos_next;
    logic [PW-1:0]            pos_count_reg, pos_count_next;

    logic          take;
    logic [PW-1:0] win_pos;
    logic [EXT_W-1:0] win_pos_ext;

    // first candidate always wins; ties go to the newer touch time
    assign take = (pos_count_reg == '0)
               || ($signed(item.rank) < best_rank_reg)
               || (($signed(item.rank) == best_rank_reg) && (item.tick > best_tick_reg));

    assign win_pos      = take ? pos_count_reg : best_pos_reg;
    assign win_pos_ext  = EXT_W'(win_pos);
    assign winner.index = win_pos_ext[IDX_W-1:0];
    assign winner.tick  = take ? item.tick : best_tick_reg;

    always_comb begin
        best_rank_next = best_rank_reg;
        best_tick_next = best_tick_reg;
        best_pos_next  = best_pos_reg;
        pos_count_next = pos_count_reg;
        if (fire) begin
            if (item.last) begin
                best_rank_next = '0;
                best_tick_next = '0;
                best_pos_next  = '0;
                pos_count_next = '0;
            end else begin
                if (take) begin
                    best_rank_next = item.rank;
                    best_tick_next = item.tick;
                    best_pos_next  = pos_count_reg;
                end
                if (pos_count_reg != POS_MAX) begin
                    pos_count_next = pos_count_reg + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_rank_reg <= '0;
            best_tick_reg <= '0;
            best_pos_reg  <= '0;
            pos_count_reg <= '0;
        end else begin
            best_rank_reg <= best_rank_next;
            best_tick_reg <= best_tick_next;
            best_pos_reg  <= best_pos_next;
            pos_count_reg <= pos_count_next;
        end
    end

`ifndef ASSERT_OFF
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_count_reg <= POS_MAX) && (best_pos_reg <= POS_MAX))
        else $error("position count out of range");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.last) |=> (pos_count_reg == '0) && (best_pos_reg == '0))
        else $error("set state not cleared after last candidate");

    a_first_takes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (pos_count_reg == '0)) |=> (best_pos_reg == '0)
                                            && ($past(item.tick) == best_tick_reg
                                                || $past(item.last)))
        else $error("first candidate not taken as winner");
`endif

endmodule

`default_nettype wire

>>> rtl/prefetch_aware_lru_victim_select_top.sv
// top level: config register, input register, rank stage, selection and result register
// pipe: input register, ranked-word register, then result register to m_valid (three-stage pipe)
// throughput: one word per cycle while the result register has room; a last word waits on m_ready
// results: one per set, on the word marked last; other words give nothing
// reset: aresetn synchronous active low, clears valids, winner state and prefetch_gap
// the config register reads back through prdata; pready is tied high
`default_nettype none

module prefetch_aware_lru_victim_select_top #(
    parameter int WAYS = plvs_pkg::WAYS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [plvs_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [plvs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [plvs_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready,
    // candidate words in
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [plvs_pkg::TICK_W-1:0]         s_now_tick,
    input  wire logic [plvs_pkg::TICK_W-1:0]         s_candidate_tick,
    input  wire logic                                s_was_prefetched,
    input  wire logic                                s_is_last,
    // victim words out
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [plvs_pkg::IDX_W-1:0]               m_victim_index,
    output logic [plvs_pkg::TICK_W-1:0]              m_victim_tick
);
    import plvs_pkg::*;

    // config register
    logic [TICK_W-1:0] gap_reg, gap_next;
    logic              reg_sel;
    logic              cfg_write;

    // stage 1: input register
    logic              v1_reg, v1_next;
    logic [TICK_W-1:0] now1_reg, now1_next;
    logic [TICK_W-1:0] tick1_reg, tick1_next;
    logic              pf1_reg, pf1_next;
    logic              last1_reg, last1_next;

    // stage 2: ranked word
    logic              v2_reg, v2_next;
    rank_word_t        w2_reg, w2_next;
    logic signed [RANK_W-1:0] rank1;

    // result register
    logic              mv_reg, mv_next;
    victim_t           res_reg, res_next;
    victim_t           winner;

    // flow control
    logic out_free;
    logic s2_fire;
    logic s2_ready;
    logic s1_move;
    logic s_fire;

    // apb: write on access phase, register select taken from address bit 3
    assign pready    = 1'b1;
    assign reg_sel   = paddr[REG_SEL_LSB];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        gap_next = gap_reg;
        if (cfg_write && (reg_sel == REG_PREFETCH_GAP)) begin
            gap_next = pwdata[TICK_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel == REG_PREFETCH_GAP) begin
            prdata = APB_DATA_W'(gap_reg);
        end
    end

    // a non-last word needs no result slot, so it retires from stage 2 without waiting on m_ready
    assign out_free = !mv_reg || m_ready;
    assign s2_fire  = v2_reg && (!w2_reg.last || out_free);
    assign s2_ready = !v2_reg || s2_fire;
    assign s1_move  = v1_reg && s2_ready;
    assign s_ready  = !v1_reg || s1_move;
    assign s_fire   = s_valid && s_ready;

    // stage 1 capture
    always_comb begin
        v1_next    = v1_reg;
        now1_next  = now1_reg;
        tick1_next = tick1_reg;
        pf1_next   = pf1_reg;
        last1_next = last1_reg;
        if (s_fire) begin
            v1_next    = 1'b1;
            now1_next  = s_now_tick;
            tick1_next = s_candidate_tick;
            pf1_next   = s_was_prefetched;
            last1_next = s_is_last;
        end else if (s1_move) begin
            v1_next = 1'b0;
        end
    end

    plvs_rank u_rank (
        .now_tick       (now1_reg),
        .candidate_tick (tick1_reg),
        .was_prefetched (pf1_reg),
        .prefetch_gap   (gap_reg),
        .rank           (rank1)
    );

    // stage 2 capture
    always_comb begin
        v2_next = v2_reg;
        w2_next = w2_reg;
        if (s1_move) begin
            v2_next      = 1'b1;
            w2_next.rank = rank1;
            w2_next.tick = tick1_reg;
            w2_next.last = last1_reg;
        end else if (s2_fire) begin
            v2_next = 1'b0;
        end
    end

    plvs_select #(
        .WAYS (WAYS)
    ) u_select (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (s2_fire),
        .item    (w2_reg),
        .winner  (winner)
    );

    // result register loads the winner when the last word of a set retires
    always_comb begin
        mv_next  = mv_reg;
        res_next = res_reg;
        if (s2_fire && w2_reg.last) begin
            mv_next  = 1'b1;
            res_next = winner;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    assign m_valid        = mv_reg;
    assign m_victim_index = res_reg.index;
    assign m_victim_tick  = res_reg.tick;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            mv_reg  <= 1'b0;
        end else begin
            gap_reg <= gap_next;
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            mv_reg  <= mv_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        now1_reg  <= now1_next;
        tick1_reg <= tick1_next;
        pf1_reg   <= pf1_next;
        last1_reg <= last1_next;
        w2_reg    <= w2_next;
        res_reg   <= res_next;
    end

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && w2_reg.last && mv_reg && !m_ready))
        else $error("input stalled with room in the pipe");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_fire && w2_reg.last) |=> m_valid)
        else $error("last word retired without a result");

    a_result_only_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid)) |-> $past(s2_fire && w2_reg.last))
        else $error("result raised without a last word");
`endif

endmodule

`default_nettype wire
